// ----- hw/rtl/tftu_pkg.sv -----
// ----------------------------------------------------------------------------
// tftu_pkg
// shared types, widths and the quarter-wave sine builder for the
// trapezoid fourier transform unit
// ----------------------------------------------------------------------------
package tftu_pkg;

    localparam int XW         = 32;
    localparam int TERM_W     = 32;
    localparam int ACC_W      = 48;
    localparam int TAB_W      = 17;
    localparam int TRIG_W     = 18;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [XW-1:0]     x;
        logic signed [TERM_W-1:0] cos_term;
        logic signed [TERM_W-1:0] sin_term;
        logic                     last;
    } t_term_word;

    typedef struct packed {
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } t_fifo_status;

    // sin of idx quarter steps, q1.16, from a 13-term series in q30
    function automatic logic [TAB_W-1:0] quarter_sine(input logic [63:0] idx,
                                                      input int qbits);
        logic [63:0]        theta;
        logic [63:0]        term;
        logic signed [63:0] sum;
        theta = (idx * HALF_PI_Q30) >> qbits;
        term  = theta;
        sum   = signed'(theta);
        for (int n = 1; n <= 12; n++) begin
            term = (((term * theta) >> 30) * theta) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        sum = (sum + 64'sd8192) >>> 14;
        if (sum > 64'sd65536) begin
            sum = 64'sd65536;
        end
        return sum[TAB_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/tftu_front.sv -----
// ----------------------------------------------------------------------------
// tftu_front
// takes sample words, forms the phase, looks up cos/sin in the quarter-wave
// rom and produces the rounded, saturated cos and sin terms for the queue
// ----------------------------------------------------------------------------
module tftu_front
    import tftu_pkg::*;
#(
    parameter int PHASE_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [XW-1:0] i_x_position,
    input  logic signed [31:0]   i_sample_value,
    input  logic                 i_last_sample,
    input  t_fifo_status         i_fifo,
    output logic                 o_push,
    output t_term_word           o_word
);

    localparam int QBITS   = PHASE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int ADDR_W  = PHASE_BITS - 1;

    typedef logic [QUARTER:0][TAB_W-1:0] t_sine_rom;

    // quarter-wave table, built at elaboration
    function automatic t_sine_rom sine_rom_init();
        t_sine_rom rom;
        for (int i = 0; i <= QUARTER; i++) begin
            rom[i] = quarter_sine(64'(i), QBITS);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_rom_init();

    logic signed [31:0] r_frequency;

    logic               r_s1_v;
    logic [31:0]        r_s1_phase;
    logic signed [31:0] r_s1_x;
    logic signed [31:0] r_s1_y;
    logic               r_s1_last;

    logic               r_s2_v;
    logic [TAB_W-1:0]   r_s2_sin_a;
    logic [TAB_W-1:0]   r_s2_sin_b;
    logic [1:0]         r_s2_quad;
    logic signed [31:0] r_s2_x;
    logic signed [31:0] r_s2_y;
    logic               r_s2_last;

    logic               r_s3_v;
    logic signed [49:0] r_s3_cos_p;
    logic signed [49:0] r_s3_sin_p;
    logic signed [31:0] r_s3_x;
    logic               r_s3_last;

    logic                w_accept;
    logic [1:0]          w_inflight;
    logic [31:0]         w_phase;
    logic [PHASE_BITS-1:0] w_idx;
    logic [ADDR_W-1:0]   w_addr_a;
    logic [ADDR_W-1:0]   w_addr_b;
    logic signed [TRIG_W-1:0] w_a;
    logic signed [TRIG_W-1:0] w_b;
    logic signed [TRIG_W-1:0] w_cos;
    logic signed [TRIG_W-1:0] w_sin;

    function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [49:0] p);
        logic signed [50:0] v;
        v = (51'(p) + 51'sd32768) >>> 16;
        if (v > 51'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -51'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[TERM_W-1:0];
    endfunction

    // credit check: queue fill plus words still in the front stages
    assign w_inflight = 2'(r_s1_v) + 2'(r_s2_v) + 2'(r_s3_v);
    assign o_in_stall = (5'(i_fifo.count) + 5'(w_inflight)) >= 5'(FIFO_DEPTH);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_phase  = 32'(r_frequency * i_x_position);
    assign w_idx    = r_s1_phase[31 -: PHASE_BITS];
    assign w_addr_a = {1'b0, w_idx[QBITS-1:0]};
    assign w_addr_b = ADDR_W'(QUARTER) - w_addr_a;

    assign w_a = signed'({1'b0, r_s2_sin_a});
    assign w_b = signed'({1'b0, r_s2_sin_b});

    always_comb begin
        unique case (r_s2_quad)
            2'd0: begin
                w_sin = w_a;
                w_cos = w_b;
            end
            2'd1: begin
                w_sin = w_b;
                w_cos = -w_a;
            end
            2'd2: begin
                w_sin = -w_a;
                w_cos = -w_b;
            end
            default: begin
                w_sin = -w_b;
                w_cos = w_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frequency <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frequency <= signed'(i_cfg_wdata);
            end
            r_s1_v <= w_accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_phase <= w_phase;
        r_s1_x     <= i_x_position;
        r_s1_y     <= i_sample_value;
        r_s1_last  <= i_last_sample;

        r_s2_sin_a <= SINE_ROM[w_addr_a];
        r_s2_sin_b <= SINE_ROM[w_addr_b];
        r_s2_quad  <= w_idx[PHASE_BITS-1 -: 2];
        r_s2_x     <= r_s1_x;
        r_s2_y     <= r_s1_y;
        r_s2_last  <= r_s1_last;

        r_s3_cos_p <= 50'(r_s2_y) * 50'(w_cos);
        r_s3_sin_p <= 50'(r_s2_y) * 50'(w_sin);
        r_s3_x     <= r_s2_x;
        r_s3_last  <= r_s2_last;
    end

    assign o_push          = r_s3_v;
    assign o_word.x        = r_s3_x;
    assign o_word.cos_term = sat_term(r_s3_cos_p);
    assign o_word.sin_term = sat_term(r_s3_sin_p);
    assign o_word.last     = r_s3_last;

endmodule

// ----- hw/rtl/tftu_fifo.sv -----
// ----------------------------------------------------------------------------
// tftu_fifo
// short queue of term words between the front and the accumulate back end
// ----------------------------------------------------------------------------
module tftu_fifo
    import tftu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_term_word   i_word,
    input  logic         i_pop,
    output t_term_word   o_word,
    output t_fifo_status o_status
);

    t_term_word         r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_word         = r_mem[r_rptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

// ----- hw/rtl/tftu_back.sv -----
// ----------------------------------------------------------------------------
// tftu_back
// trapezoid step: (term + previous term) * dx / 2, saturating accumulate,
// result word on the last sample of a pass
// ----------------------------------------------------------------------------
module tftu_back
    import tftu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_fifo_status            i_fifo,
    input  t_term_word              i_word,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [ACC_W-1:0] o_real_part,
    output logic signed [ACC_W-1:0] o_imag_part
);

    logic               r_first;
    logic signed [31:0] r_prev_x;
    logic signed [31:0] r_prev_ct;
    logic signed [31:0] r_prev_st;

    logic               r_b1_v;
    logic signed [32:0] r_b1_sum_c;
    logic signed [32:0] r_b1_sum_s;
    logic signed [32:0] r_b1_dx;
    logic               r_b1_first;
    logic               r_b1_last;

    logic               r_b2_v;
    logic [32:0]        r_b2_mag_c;
    logic [32:0]        r_b2_mag_s;
    logic [32:0]        r_b2_mag_dx;
    logic               r_b2_neg_c;
    logic               r_b2_neg_s;
    logic               r_b2_first;
    logic               r_b2_last;

    logic               r_b3_v;
    logic [65:0]        r_b3_prod_c;
    logic [65:0]        r_b3_prod_s;
    logic               r_b3_neg_c;
    logic               r_b3_neg_s;
    logic               r_b3_first;
    logic               r_b3_last;

    logic               r_b4_v;
    logic signed [49:0] r_b4_inc_c;
    logic signed [49:0] r_b4_inc_s;
    logic               r_b4_last;

    logic signed [ACC_W-1:0] r_acc_c;
    logic signed [ACC_W-1:0] r_acc_s;
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_real;
    logic signed [ACC_W-1:0] r_imag;

    logic                    w_en;
    logic signed [ACC_W-1:0] n_acc_c;
    logic signed [ACC_W-1:0] n_acc_s;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [49:0] round_inc(input logic [65:0] p,
                                                     input logic neg,
                                                     input logic first);
        logic [65:0]        r;
        logic signed [49:0] m;
        r = (p + 66'd65536) >> 17;
        m = signed'({1'b0, r[48:0]});
        if (first) begin
            return '0;
        end
        return neg ? -m : m;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [49:0] b);
        logic signed [50:0] v;
        v = 51'(a) + 51'(b);
        if (v > 51'sd140737488355327) begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end else if (v < -51'sd140737488355328) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end
        return v[ACC_W-1:0];
    endfunction

    // whole back end holds while a result waits on a stalled output
    assign w_en  = !r_out_valid || !i_out_stall;
    assign o_pop = w_en && !i_fifo.empty;

    assign n_acc_c = sat_add(r_acc_c, r_b4_inc_c);
    assign n_acc_s = sat_add(r_acc_s, r_b4_inc_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_prev_x    <= '0;
            r_prev_ct   <= '0;
            r_prev_st   <= '0;
            r_b1_v      <= 1'b0;
            r_b2_v      <= 1'b0;
            r_b3_v      <= 1'b0;
            r_b4_v      <= 1'b0;
            r_acc_c     <= '0;
            r_acc_s     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_b1_v      <= o_pop;
            r_b2_v      <= r_b1_v;
            r_b3_v      <= r_b2_v;
            r_b4_v      <= r_b3_v;
            r_out_valid <= r_b4_v && r_b4_last;
            if (o_pop) begin
                r_first   <= i_word.last;
                r_prev_x  <= i_word.x;
                r_prev_ct <= i_word.cos_term;
                r_prev_st <= i_word.sin_term;
            end
            if (r_b4_v) begin
                if (r_b4_last) begin
                    r_acc_c <= '0;
                    r_acc_s <= '0;
                end else begin
                    r_acc_c <= n_acc_c;
                    r_acc_s <= n_acc_s;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_sum_c <= 33'(i_word.cos_term) + 33'(r_prev_ct);
            r_b1_sum_s <= 33'(i_word.sin_term) + 33'(r_prev_st);
            r_b1_dx    <= 33'(i_word.x) - 33'(r_prev_x);
            r_b1_first <= r_first;
            r_b1_last  <= i_word.last;

            r_b2_mag_c  <= mag33(r_b1_sum_c);
            r_b2_mag_s  <= mag33(r_b1_sum_s);
            r_b2_mag_dx <= mag33(r_b1_dx);
            r_b2_neg_c  <= r_b1_sum_c[32] ^ r_b1_dx[32];
            r_b2_neg_s  <= r_b1_sum_s[32] ^ r_b1_dx[32];
            r_b2_first  <= r_b1_first;
            r_b2_last   <= r_b1_last;

            r_b3_prod_c <= 66'(r_b2_mag_c) * 66'(r_b2_mag_dx);
            r_b3_prod_s <= 66'(r_b2_mag_s) * 66'(r_b2_mag_dx);
            r_b3_neg_c  <= r_b2_neg_c;
            r_b3_neg_s  <= r_b2_neg_s;
            r_b3_first  <= r_b2_first;
            r_b3_last   <= r_b2_last;

            r_b4_inc_c <= round_inc(r_b3_prod_c, r_b3_neg_c, r_b3_first);
            r_b4_inc_s <= round_inc(r_b3_prod_s, r_b3_neg_s, r_b3_first);
            r_b4_last  <= r_b3_last;

            if (r_b4_v && r_b4_last) begin
                r_real <= n_acc_c;
                r_imag <= n_acc_s;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_real_part = r_real;
    assign o_imag_part = r_imag;

endmodule

// ----- hw/rtl/trapezoid_fourier_transform_unit.sv -----
// ----------------------------------------------------------------------------
// trapezoid_fourier_transform_unit
// trapezoidal-rule fourier transform of a nonuniformly sampled stream at one
// configured frequency, q16.16 in, q32.16 saturated out
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------
//   cfg     | i_cfg_we   | -           | i_cfg_wdata (frequency)
//   in      | i_in_valid | o_in_stall  | i_x_position i_sample_value
//           |            |             | i_last_sample
//   out     | o_out_valid| i_out_stall | o_real_part o_imag_part
//
// one sample word per cycle while o_in_stall is low; the rate is set by the
// single accumulate loop; with the queue empty a last sample reaches
// o_out_valid through the first front stage, loaded at the edge that accepts
// it, then 2 front stages, the queue, 4 back stages and the output register
// i_rst_n is synchronous; it clears frequency, pass state and accumulators
// o_in_stall rises once the 8-entry queue plus front words in flight fill up
// a held result under i_out_stall freezes the back end until it is taken
// ----------------------------------------------------------------------------
module trapezoid_fourier_transform_unit
    import tftu_pkg::*;
#(
    parameter int PHASE_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [31:0]             i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [XW-1:0]    i_x_position,
    input  logic signed [31:0]      i_sample_value,
    input  logic                    i_last_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [ACC_W-1:0] o_real_part,
    output logic signed [ACC_W-1:0] o_imag_part
);

    t_fifo_status w_status;
    t_term_word   w_push_word;
    t_term_word   w_pop_word;
    logic         w_push;
    logic         w_pop;

    tftu_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_x_position   (i_x_position),
        .i_sample_value (i_sample_value),
        .i_last_sample  (i_last_sample),
        .i_fifo         (w_status),
        .o_push         (w_push),
        .o_word         (w_push_word)
    );

    tftu_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_word   (w_push_word),
        .i_pop    (w_pop),
        .o_word   (w_pop_word),
        .o_status (w_status)
    );

    tftu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo      (w_status),
        .i_word      (w_pop_word),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_real_part (o_real_part),
        .o_imag_part (o_imag_part)
    );

    // front credit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_status.count != FIFO_CW'(FIFO_DEPTH)))
        else $error("term queue overflow");

    // queue fill goes up by one after a push without a pop
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && w_status.count != FIFO_CW'(FIFO_DEPTH))
            |=> (w_status.count == $past(w_status.count) + 1'b1))
        else $error("queue count lost a push");

    // reset leaves no result and no queued word behind
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && w_status.empty))
        else $error("state left after reset");

endmodule
